// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the aliquot sum classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define ASC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent in a cycle implies the consequent in the next cycle.
`define ASC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/ascu_pkg.sv =====
// Types and constants of the aliquot sum classifier.
`timescale 1ns / 1ps
`default_nettype none

package ascu_pkg;

    localparam int NUM_OUT_W = 16;
    localparam int SUM_OUT_W = 18;
    localparam int KIND_W    = 2;

    localparam logic [SUM_OUT_W-1:0] SUM_MAX = 18'd262143;

    typedef enum logic [KIND_W-1:0] {
        KIND_DEFICIENT = 2'd0,
        KIND_PERFECT   = 2'd1,
        KIND_ABUNDANT  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ascu_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ascu_divider #(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it always fits in W bits.
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ascu_seq.sv =====
// Sequencer that walks trial divisors and accumulates divisor pairs.
`timescale 1ns / 1ps
`default_nettype none

module ascu_seq
    import ascu_pkg::*;
#(
    parameter int NUM_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [NUM_OUT_W-1:0]   s_number,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output logic [NUM_WIDTH-1:0]        res_num,
    output logic [NUM_WIDTH+2:0]        res_sum
);

    localparam int SUM_W = NUM_WIDTH + 3;

    seq_state_t           state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [NUM_WIDTH-1:0] n_in;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_WIDTH-1:0] div_quo;
    logic [NUM_WIDTH-1:0] div_rem;
    logic [SUM_W-1:0]     pair_add;

    assign n_in = NUM_WIDTH'(s_number);

    // A divisor equal to its cofactor (a square root) is counted once.
    assign pair_add = SUM_W'(d_reg) + ((div_quo != d_reg) ? SUM_W'(div_quo) : '0);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sum_next   = sum_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next = n_in;
                    d_next = NUM_WIDTH'(2);
                    if (n_in < NUM_WIDTH'(4)) begin
                        sum_next   = (n_in == NUM_WIDTH'(1)) ? '0 : SUM_W'(1);
                        state_next = ST_DONE;
                    end else begin
                        sum_next   = SUM_W'(1);
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    // n / d below d means d * d exceeds n: the search is over.
                    if (div_quo < d_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        if (div_rem == '0) begin
                            sum_next = sum_reg + pair_add;
                        end
                        d_next     = d_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg   <= n_next;
        d_reg   <= d_next;
        sum_reg <= sum_next;
    end

    ascu_divider #(
        .W(NUM_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_num   = n_reg;
    assign res_sum   = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/aliquot_sum_classifier_unit.sv =====
// Top level of the aliquot sum classifier: sequencer, classification and result register.
//
//  channel  direction  ports                                         transfer when
//  s_       in         s_valid s_ready s_number                      s_valid & s_ready
//  m_       out        m_valid m_ready m_number_echo m_divisor_sum   m_valid & m_ready
//                      m_kind
//
// One number at a time. Each trial divisor d (from 2 up to the first d with d * d > n)
// is tried in turn on the shared restoring divider; inputs below four skip the divider.
// Reset is synchronous and clears the control state only. A stalled result sits in the
// output register while the next number is already accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aliquot_sum_classifier_unit
    import ascu_pkg::*;
#(
    parameter int NUM_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [NUM_OUT_W-1:0]  s_number,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [NUM_OUT_W-1:0]       m_number_echo,
    output logic [SUM_OUT_W-1:0]       m_divisor_sum,
    output logic [KIND_W-1:0]          m_kind
);

    localparam int SUM_W = NUM_WIDTH + 3;
    localparam int CMP_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

    logic                 res_valid;
    logic                 res_ready;
    logic [NUM_WIDTH-1:0] res_num;
    logic [SUM_W-1:0]     res_sum;
    logic [SUM_W-1:0]     num_wide;
    kind_t                kind;
    logic [SUM_OUT_W-1:0] sum_sat;

    logic                 m_valid_reg, m_valid_next;
    logic [NUM_OUT_W-1:0] echo_reg, echo_next;
    logic [SUM_OUT_W-1:0] sum_reg, sum_next;
    kind_t                kind_reg, kind_next;

    ascu_seq #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_number  (s_number),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_num   (res_num),
        .res_sum   (res_sum)
    );

    // The class is decided on the full sum, before saturation.
    assign num_wide = SUM_W'(res_num);

    always_comb begin
        if (res_sum < num_wide) begin
            kind = KIND_DEFICIENT;
        end else if (res_sum == num_wide) begin
            kind = KIND_PERFECT;
        end else begin
            kind = KIND_ABUNDANT;
        end
    end

    assign sum_sat = (CMP_W'(res_sum) > CMP_W'(SUM_MAX)) ? SUM_MAX : SUM_OUT_W'(res_sum);

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        echo_next    = echo_reg;
        sum_next     = sum_reg;
        kind_next    = kind_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            echo_next    = NUM_OUT_W'(res_num);
            sum_next     = sum_sat;
            kind_next    = kind;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        echo_reg <= echo_next;
        sum_reg  <= sum_next;
        kind_reg <= kind_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_number_echo = echo_reg;
    assign m_divisor_sum = sum_reg;
    assign m_kind        = kind_reg;

    // A perfect number's divisor sum is the number itself.
    `ASC_ASSERT_SAME(a_perfect_sum, aclk, aresetn,
        m_valid && (m_kind == KIND_PERFECT), m_divisor_sum == SUM_OUT_W'(m_number_echo))
    // The number one has no proper divisors.
    `ASC_ASSERT_SAME(a_one_zero_sum, aclk, aresetn,
        m_valid && (m_number_echo == NUM_OUT_W'(1)), m_divisor_sum == '0)
    // After a transfer in, the block is busy until the sum is done.
    `ASC_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

`default_nettype wire
